[rtl/a2b_pkg.sv]
// Shared types, constants and helpers for the avcC to Annex B converter.
package a2b_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrW      = $clog2(QueueDepth);
   localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

   localparam logic [7:0]  NalMask   = 8'h1F;
   localparam logic [15:0] MinParsed = 16'd7;
   localparam logic [15:0] PassMin   = 16'd3;
   localparam logic [15:0] CountPos  = 16'd5;

   typedef enum logic [3:0] {
      PH_START,
      PH_ZERO1,
      PH_ZERO2,
      PH_PASS,
      PH_SKIP,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAYLOAD,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      RUN_EMPTY,
      RUN_BYTE,
      RUN_TRIPLE,
      RUN_START
   } run_kind_type;

   typedef struct packed {
      run_kind_type kind;
      logic [7:0]   data;
      logic         record_end;
   } run_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Index of the last result of a run of the given kind.
   function automatic logic [1:0] last_index(input run_kind_type kind);
      logic [1:0] idx;
      unique case (kind)
         RUN_EMPTY:  idx = 2'd0;
         RUN_BYTE:   idx = 2'd0;
         RUN_TRIPLE: idx = 2'd2;
         RUN_START:  idx = 2'd3;
         default:    idx = 2'd0;
      endcase
      return idx;
   endfunction

   // Bytes of the 00 00 00 01 start code.
   function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
      return (idx == 2'd3) ? 8'h01 : 8'h00;
   endfunction

endpackage

[rtl/a2b_front.sv]
// Record parser: accepts input bytes and classifies each into an output run.
module a2b_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_data_byte,
   input  logic [15:0]           req_record_length,
   input  logic                  room,
   output logic                  push_valid,
   output a2b_pkg::run_cmd_type  push_cmd
);

   a2b_pkg::phase_type phase_ff, phase_in, phase_nx;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  units_ff, units_in;
   logic        pps_ff, pps_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [15:0] payload_ff, payload_in;

   logic        accept;
   logic        is_final;
   logic        fits2;
   logic        overrun;
   logic [15:0] unit_len;
   logic        skip_done;

   assign accept    = req_valid & room;
   assign is_final  = ({1'b0, pos_ff} + 17'd1) >= {1'b0, req_record_length};
   assign fits2     = ({1'b0, pos_ff} + 17'd2) <= {1'b0, req_record_length};
   assign unit_len  = {len_high_ff, req_data_byte};
   assign overrun   = ({2'b00, pos_ff} + 18'd1 + {2'b00, unit_len})
                      > {2'b00, req_record_length};
   assign skip_done = pos_ff >= a2b_pkg::CountPos;

   // Next phase
   always_comb begin
      phase_nx = phase_ff;
      unique case (phase_ff)
         a2b_pkg::PH_START: begin
            if (req_data_byte == 8'h00) begin
               phase_nx = a2b_pkg::PH_ZERO1;
            end else if (req_data_byte == 8'h01 &&
                         req_record_length >= a2b_pkg::MinParsed) begin
               phase_nx = a2b_pkg::PH_SKIP;
            end else begin
               phase_nx = a2b_pkg::PH_IDLE;
            end
         end
         a2b_pkg::PH_ZERO1: begin
            phase_nx = (req_data_byte == 8'h00) ? a2b_pkg::PH_ZERO2 : a2b_pkg::PH_IDLE;
         end
         a2b_pkg::PH_ZERO2: begin
            if ((req_data_byte == 8'h00 || req_data_byte == 8'h01) &&
                req_record_length >= a2b_pkg::PassMin) begin
               phase_nx = a2b_pkg::PH_PASS;
            end else begin
               phase_nx = a2b_pkg::PH_IDLE;
            end
         end
         a2b_pkg::PH_PASS: phase_nx = a2b_pkg::PH_PASS;
         a2b_pkg::PH_SKIP: begin
            phase_nx = skip_done ? a2b_pkg::PH_LEN_HI : a2b_pkg::PH_SKIP;
         end
         a2b_pkg::PH_LEN_HI: begin
            if (units_ff != 8'd0 && fits2) begin
               phase_nx = a2b_pkg::PH_LEN_LO;
            end else if (!pps_ff) begin
               phase_nx = a2b_pkg::PH_LEN_HI;
            end else begin
               phase_nx = a2b_pkg::PH_IDLE;
            end
         end
         a2b_pkg::PH_LEN_LO: begin
            if (overrun) begin
               phase_nx = pps_ff ? a2b_pkg::PH_IDLE : a2b_pkg::PH_LEN_HI;
            end else if (unit_len == 16'd0) begin
               phase_nx = a2b_pkg::PH_LEN_HI;
            end else begin
               phase_nx = a2b_pkg::PH_PAYLOAD;
            end
         end
         a2b_pkg::PH_PAYLOAD: begin
            phase_nx = (payload_ff == 16'd1) ? a2b_pkg::PH_LEN_HI : a2b_pkg::PH_PAYLOAD;
         end
         a2b_pkg::PH_IDLE: phase_nx = a2b_pkg::PH_IDLE;
         default:          phase_nx = a2b_pkg::PH_IDLE;
      endcase
      // A record's final byte returns everything to the start of the next record
      phase_in = is_final ? a2b_pkg::PH_START : phase_nx;
   end

   // Run command and counters
   always_comb begin
      push_cmd.kind       = a2b_pkg::RUN_EMPTY;
      push_cmd.data       = req_data_byte;
      push_cmd.record_end = is_final;
      units_in    = units_ff;
      pps_in      = pps_ff;
      len_high_in = len_high_ff;
      payload_in  = payload_ff;
      unique case (phase_ff)
         a2b_pkg::PH_ZERO2: begin
            if ((req_data_byte == 8'h00 || req_data_byte == 8'h01) &&
                req_record_length >= a2b_pkg::PassMin) begin
               push_cmd.kind = a2b_pkg::RUN_TRIPLE;
            end
         end
         a2b_pkg::PH_PASS: push_cmd.kind = a2b_pkg::RUN_BYTE;
         a2b_pkg::PH_SKIP: begin
            if (skip_done) begin
               units_in = req_data_byte & a2b_pkg::NalMask;
               pps_in   = 1'b0;
            end
         end
         a2b_pkg::PH_LEN_HI: begin
            if (units_ff != 8'd0 && fits2) begin
               len_high_in = req_data_byte;
            end else if (!pps_ff) begin
               // Loop ended: this byte is the PPS count
               units_in = req_data_byte;
               pps_in   = 1'b1;
            end
         end
         a2b_pkg::PH_LEN_LO: begin
            if (overrun) begin
               if (!pps_ff) begin
                  units_in = 8'd0;
               end
            end else begin
               push_cmd.kind = a2b_pkg::RUN_START;
               units_in      = units_ff - 8'd1;
               if (unit_len != 16'd0) begin
                  payload_in = unit_len;
               end
            end
         end
         a2b_pkg::PH_PAYLOAD: begin
            push_cmd.kind = a2b_pkg::RUN_BYTE;
            payload_in    = payload_ff - 16'd1;
         end
         default: begin
         end
      endcase
      if (is_final) begin
         pos_in      = 16'd0;
         units_in    = 8'd0;
         pps_in      = 1'b0;
         len_high_in = 8'd0;
         payload_in  = 16'd0;
      end else begin
         pos_in = pos_ff + 16'd1;
      end
   end

   assign push_valid = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= a2b_pkg::PH_START;
         pos_ff      <= 16'd0;
         units_ff    <= 8'd0;
         pps_ff      <= 1'b0;
         len_high_ff <= 8'd0;
         payload_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         units_ff    <= units_in;
         pps_ff      <= pps_in;
         len_high_ff <= len_high_in;
         payload_ff  <= payload_in;
      end
   end

endmodule

[rtl/a2b_queue.sv]
// Short command queue between the parser and the byte emitter.
module a2b_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  a2b_pkg::run_cmd_type      push_cmd,
   input  logic                      pop,
   output a2b_pkg::run_cmd_type      head_cmd,
   output a2b_pkg::queue_status_type status,
   output logic [a2b_pkg::QCntW-1:0] count
);

   a2b_pkg::run_cmd_type slot_ff [a2b_pkg::QueueDepth];
   logic [a2b_pkg::QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [a2b_pkg::QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [a2b_pkg::QCntW-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == a2b_pkg::QCntW'(a2b_pkg::QueueDepth));
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign count        = count_ff;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + a2b_pkg::QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + a2b_pkg::QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + a2b_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - a2b_pkg::QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/a2b_back.sv]
// Byte emitter: expands queued run commands into result items.
module a2b_back (
   input  logic                      clock,
   input  logic                      reset,
   input  a2b_pkg::run_cmd_type      head_cmd,
   input  a2b_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_last_of_run,
   output logic                      rsp_record_end
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       last_ff, last_in;
   logic       rend_ff;
   logic       out_free;
   logic       load;

   assign out_free = ~valid_ff | ~rsp_stall;
   assign load     = out_free & ~status.empty;
   assign last_in  = (idx_ff == a2b_pkg::last_index(head_cmd.kind));
   assign pop      = load & last_in;

   always_comb begin
      byte_in   = 8'h00;
      bvalid_in = 1'b1;
      unique case (head_cmd.kind)
         a2b_pkg::RUN_EMPTY: bvalid_in = 1'b0;
         a2b_pkg::RUN_BYTE:  byte_in = head_cmd.data;
         a2b_pkg::RUN_TRIPLE: begin
            byte_in = (idx_ff == 2'd2) ? head_cmd.data : 8'h00;
         end
         a2b_pkg::RUN_START: byte_in = a2b_pkg::start_code_byte(idx_ff);
         default:            bvalid_in = 1'b0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         // Advance within the run, restart at the next command
         idx_in   = last_in ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         rend_ff   <= head_cmd.record_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_record_end  = rend_ff;

endmodule

[rtl/avcc_config_to_annexb.sv]
// Top level of the avcC decoder configuration record to Annex B converter.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_data_byte, req_record_length
//   rsp     | out       | rsp_valid, rsp_stall, rsp_out_byte, rsp_byte_valid,
//           |           | rsp_last_of_run, rsp_record_end
//
// One input item is taken per cycle while the four-entry run queue has room.
// Each item yields 1 to 4 result items, sent one per cycle from the output
// register while rsp_stall is low; frequent start-code runs (4 results) set the sustained rate.
// Synchronous reset clears parser state, queue and output valid.
// req_stall rises only when the queue is full; rsp_stall holds the output register.
module avcc_config_to_annexb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_record_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic        rsp_record_end
);

   logic                      push_valid;
   a2b_pkg::run_cmd_type      push_cmd;
   a2b_pkg::run_cmd_type      head_cmd;
   a2b_pkg::queue_status_type q_status;
   logic [a2b_pkg::QCntW-1:0] q_count;
   logic                      pop;

   assign req_stall = q_status.full;

   a2b_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_data_byte     (req_data_byte),
      .req_record_length (req_record_length),
      .room              (~q_status.full),
      .push_valid        (push_valid),
      .push_cmd          (push_cmd)
   );

   a2b_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status),
      .count    (q_count)
   );

   a2b_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .status          (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_record_end  (rsp_record_end)
   );

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_empty_run_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_of_run && rsp_out_byte == 8'h00)
      else $error("empty run item malformed");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |=> rsp_valid)
      else $error("run broken before its last item");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= a2b_pkg::QCntW'(a2b_pkg::QueueDepth) && !(push_valid && q_status.full))
      else $error("run queue overflow");

endmodule
